/* rtl/core/tchpc_pkg.sv */
// Package for the two-choice hash packet counter.
// Types, codes and the rotate helper of the MurmurHash3 rounds; no dependencies.
package tchpc_pkg;

    localparam int TABLE_DEPTH_DEF = 65536;
    localparam int KEY_W   = 32;
    localparam int CNT_W   = 32;
    localparam int IDX_W   = 16;
    localparam int TSIZE_W = 17;

    typedef enum logic [1:0] {
        OP_COUNT = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_HIT_ONE = 3'd0,
        ST_HIT_TWO = 3'd1,
        ST_NEW_ONE = 3'd2,
        ST_NEW_TWO = 3'd3,
        ST_DROPPED = 3'd4,
        ST_CLEARED = 3'd5,
        ST_READ    = 3'd6
    } t_status;

    localparam logic [1:0] CFG_SEED_ONE = 2'd0;
    localparam logic [1:0] CFG_SEED_TWO = 2'd1;
    localparam logic [1:0] CFG_TSIZE    = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HASH,
        S_MOD,
        S_RDA,
        S_RDB,
        S_WAITB,
        S_DECIDE,
        S_CLEAR,
        S_RDX,
        S_RDXW,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] slot_index;
        logic [31:0] slot_key;
        logic [31:0] slot_count;
    } t_result;

    typedef struct packed {
        logic        start;
        logic [31:0] key;
        logic [31:0] seed;
    } t_hash_req;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
        rotl = (x << r) | (x >> (32 - r));
    endfunction

endpackage

/* rtl/core/tchpc_hash.sv */
// MurmurHash3 x86_32 of one 4-byte key, one multiply per cycle.
// Depends on tchpc_pkg.
module tchpc_hash import tchpc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_hash_req   i_req,
    output logic        o_done,
    output logic [31:0] o_hash
);
    logic [2:0]  r_step, n_step;
    logic [31:0] r_k, n_k;
    logic [31:0] r_h, n_h;
    logic [31:0] r_seed, n_seed;
    logic        r_done, n_done;
    logic [31:0] w_h1;

    assign w_h1 = rotl(r_seed ^ r_k, 13);

    always_comb begin
        n_step = r_step;
        n_k    = r_k;
        n_h    = r_h;
        n_seed = r_seed;
        n_done = 1'b0;
        case (r_step)
            3'd0: if (i_req.start) begin
                n_k    = i_req.key * 32'hcc9e2d51;
                n_seed = i_req.seed;
                n_step = 3'd1;
            end
            3'd1: begin
                n_k    = rotl(r_k, 15) * 32'h1b873593;
                n_step = 3'd2;
            end
            3'd2: begin
                n_h    = (w_h1 * 32'd5 + 32'he6546b64) ^ 32'd4;
                n_step = 3'd3;
            end
            3'd3: begin
                n_h    = (r_h ^ (r_h >> 16)) * 32'h85ebca6b;
                n_step = 3'd4;
            end
            3'd4: begin
                n_h    = (r_h ^ (r_h >> 13)) * 32'hc2b2ae35;
                n_step = 3'd5;
            end
            3'd5: begin
                n_h    = r_h ^ (r_h >> 16);
                n_done = 1'b1;
                n_step = 3'd0;
            end
            default: n_step = 3'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 3'd0;
            r_done <= 1'b0;
        end else begin
            r_step <= n_step;
            r_done <= n_done;
        end
        r_k    <= n_k;
        r_h    <= n_h;
        r_seed <= n_seed;
    end

    assign o_done = r_done;
    assign o_hash = r_h;
endmodule

/* rtl/core/tchpc_mod.sv */
// Restoring remainder of a 32-bit value by the slot count, one bit a cycle.
// Depends on tchpc_pkg.
module tchpc_mod import tchpc_pkg::*; #(
    parameter int DIV_W = 21
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [31:0]      i_num,
    input  logic [DIV_W-1:0] i_div,
    output logic             o_done,
    output logic [DIV_W-1:0] o_rem
);
    logic [31:0]      r_num;
    logic [DIV_W:0]   r_rem;
    logic [5:0]       r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DIV_W:0]   w_sh;

    assign w_sh = {r_rem[DIV_W-1:0], r_num[31]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
                r_num  <= i_num;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_num <= r_num << 1;
                if (w_sh >= {1'b0, i_div}) r_rem <= w_sh - {1'b0, i_div};
                else r_rem <= w_sh;
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[DIV_W-1:0];
endmodule

/* rtl/core/tchpc_table.sv */
// Slot memory: key and count per entry, one port, registered read.
// Depends on tchpc_pkg.
module tchpc_table import tchpc_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int AW = $clog2(TABLE_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [31:0]   i_wkey,
    input  logic [31:0]   i_wcnt,
    output logic [31:0]   o_rkey,
    output logic [31:0]   o_rcnt
);
    logic [63:0] r_mem [TABLE_DEPTH];
    logic [63:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= {i_wkey, i_wcnt};
        r_rd <= r_mem[i_addr];
    end

    assign o_rkey = r_rd[63:32];
    assign o_rcnt = r_rd[31:0];
endmodule

/* rtl/core/two_choice_hash_packet_counter.sv */
// Top level of the two-choice hash packet counter: sequencer around the
// hash unit, the remainder unit and the slot memory. Depends on tchpc_pkg.
//
// channel  dir  handshake            payload
// s_axis   in   s_axis_tvalid/tready tdata: key[31:0] read_index[47:32]; tuser: operation
// m_axis   out  m_axis_tvalid/tready tdata: slot_index, slot_key, slot_count; tuser: status
// cfg      in   i_cfg_valid/o_cfg_ready  index[1:0], data[31:0]
//
// A count word runs two passes of start, six hash rounds and the bit-serial remainder,
// then the states S_RDA, S_RDB, S_WAITB and S_DECIDE and the output load. A read
// passes S_RDX and S_RDXW, a dropped or unknown word goes straight to S_OUT, and a
// clear sweeps every slot in S_CLEAR. After reset the memory is swept once before
// the first word is taken. A finished word waits in the output register while the
// next one is taken; its result holds in S_OUT until the output register drains.
module two_choice_hash_packet_counter import tchpc_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // key[31:0], read_index[47:32]
    input  logic [1:0]  s_axis_tuser,   // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // slot_index[15:0], slot_key[47:16], slot_count[79:48]
    output logic [2:0]  m_axis_tuser,   // status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int DIV_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [AW:0] DEPTH_N = (AW + 1)'(TABLE_DEPTH);

    t_state r_state, n_state;
    logic [31:0] r_seed1, r_seed2;
    logic [16:0] r_tsize;
    logic [31:0] r_key;
    logic [15:0] r_ridx;
    logic        r_second;
    logic [AW-1:0] r_a, r_b;
    logic [31:0] r_ka, r_ca;
    logic [AW:0] r_clr;
    logic        r_init;
    t_result     r_res;
    t_result     r_out;
    logic        r_ovalid;
    logic        r_hstart;

    t_hash_req   w_hreq;
    logic        w_hdone, w_mdone;
    logic [31:0] w_hash;
    logic [DIV_W-1:0] w_div, w_rem;
    logic [AW:0] w_ts;
    logic        w_we;
    logic [AW-1:0] w_addr;
    logic [31:0] w_wkey, w_wcnt, w_rkey, w_rcnt;
    logic        w_acc;
    logic        w_out_load;
    logic        w_hit_a, w_hit_b;

    always_comb begin
        w_ts = (AW + 1)'(r_tsize);
        if (r_tsize == 17'd0) w_ts = (AW + 1)'(1);
        else if ({15'd0, r_tsize} > 32'(TABLE_DEPTH)) w_ts = DEPTH_N;
    end
    assign w_div = DIV_W'(w_ts);

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_acc = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;
    assign w_out_load = (r_state == S_OUT) && (!r_ovalid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed1 <= '0;
            r_seed2 <= '0;
            r_tsize <= 17'd65536;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SEED_ONE: r_seed1 <= i_cfg_data;
                CFG_SEED_TWO: r_seed2 <= i_cfg_data;
                CFG_TSIZE:    r_tsize <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    assign w_hreq = '{start: r_hstart, key: r_key, seed: (r_second ? r_seed2 : r_seed1)};

    tchpc_hash u_hash (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req(w_hreq),
        .o_done(w_hdone), .o_hash(w_hash)
    );

    tchpc_mod #(.DIV_W(DIV_W)) u_mod (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_hdone), .i_num(w_hash),
        .i_div(w_div), .o_done(w_mdone), .o_rem(w_rem)
    );

    tchpc_table #(.TABLE_DEPTH(TABLE_DEPTH), .AW(AW)) u_tab (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr), .i_wkey(w_wkey),
        .i_wcnt(w_wcnt), .o_rkey(w_rkey), .o_rcnt(w_rcnt)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_acc) begin
                if (s_axis_tuser == OP_CLEAR) n_state = S_CLEAR;
                else if (s_axis_tuser == OP_READ) n_state = S_RDX;
                else if (s_axis_tuser == OP_NONE || s_axis_tdata[31:0] == '0)
                    n_state = S_OUT;
                else n_state = S_HASH;
            end
            S_HASH:   if (w_mdone) n_state = r_second ? S_RDA : S_HASH;
            S_RDA:    n_state = S_RDB;
            S_RDB:    n_state = S_WAITB;
            S_WAITB:  n_state = S_DECIDE;
            S_DECIDE: n_state = S_OUT;
            S_CLEAR:  if (r_clr == DEPTH_N - 1'b1) n_state = r_init ? S_IDLE : S_OUT;
            S_RDX:    n_state = S_RDXW;
            S_RDXW:   n_state = S_OUT;
            S_OUT:    if (w_out_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    assign w_hit_a = (r_ka == r_key);
    assign w_hit_b = (w_rkey == r_key);

    // outputs to memory
    always_comb begin
        w_we   = 1'b0;
        w_addr = r_a;
        w_wkey = r_key;
        w_wcnt = 32'd1;
        unique case (r_state)
            S_CLEAR: begin
                w_we = 1'b1;
                w_addr = r_clr[AW-1:0];
                w_wkey = '0;
                w_wcnt = '0;
            end
            S_RDA: w_addr = r_a;
            S_RDB, S_WAITB: w_addr = r_b;
            S_RDX: w_addr = AW'(r_ridx);
            S_DECIDE: begin
                if (w_hit_a) begin
                    w_we = 1'b1; w_addr = r_a; w_wcnt = r_ca + 32'd1;
                end else if (w_hit_b) begin
                    w_we = 1'b1; w_addr = r_b; w_wcnt = w_rcnt + 32'd1;
                end else if (r_ka == '0) begin
                    w_we = 1'b1; w_addr = r_a;
                end else if (w_rkey == '0) begin
                    w_we = 1'b1; w_addr = r_b;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_init   <= 1'b1;
            r_ovalid <= 1'b0;
            r_second <= 1'b0;
            r_hstart <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_hstart <= 1'b0;
            if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            if (r_state == S_CLEAR) r_clr <= r_clr + 1'b1;
            if (r_state == S_CLEAR && r_clr == DEPTH_N - 1'b1) r_init <= 1'b0;
            if (w_acc) begin
                r_second <= 1'b0;
                r_clr    <= '0;
                if (s_axis_tuser == OP_COUNT && s_axis_tdata[31:0] != '0) r_hstart <= 1'b1;
            end
            if (r_state == S_HASH && w_mdone && !r_second) begin
                r_second <= 1'b1;
                r_hstart <= 1'b1;
            end
            if (w_out_load) r_ovalid <= 1'b1;
        end
        if (w_out_load) r_out <= r_res;
        if (w_acc) begin
            r_key  <= s_axis_tdata[31:0];
            r_ridx <= s_axis_tdata[47:32];
            r_res  <= '{status: (s_axis_tuser == OP_CLEAR) ? ST_CLEARED : ST_DROPPED,
                        slot_index: '0, slot_key: '0, slot_count: '0};
        end
        if (r_state == S_HASH && w_mdone) begin
            if (r_second) r_b <= AW'(w_rem);
            else r_a <= AW'(w_rem);
        end
        if (r_state == S_RDB) begin
            r_ka <= w_rkey;
            r_ca <= w_rcnt;
        end
        if (r_state == S_RDXW) begin
            r_res.status     <= ST_READ;
            r_res.slot_index <= r_ridx;
            if ({16'd0, r_ridx} < 32'(TABLE_DEPTH)) begin
                r_res.slot_key   <= w_rkey;
                r_res.slot_count <= w_rcnt;
            end
        end
        if (r_state == S_DECIDE) begin
            r_res.slot_key <= r_key;
            r_res.slot_count <= 32'd1;
            if (w_hit_a) begin
                r_res.status <= ST_HIT_ONE; r_res.slot_index <= 16'(r_a);
                r_res.slot_count <= r_ca + 32'd1;
            end else if (w_hit_b) begin
                r_res.status <= ST_HIT_TWO; r_res.slot_index <= 16'(r_b);
                r_res.slot_count <= w_rcnt + 32'd1;
            end else if (r_ka == '0) begin
                r_res.status <= ST_NEW_ONE; r_res.slot_index <= 16'(r_a);
            end else if (w_rkey == '0) begin
                r_res.status <= ST_NEW_TWO; r_res.slot_index <= 16'(r_b);
            end else begin
                r_res.status <= ST_DROPPED; r_res.slot_index <= '0;
                r_res.slot_key <= '0; r_res.slot_count <= '0;
            end
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {r_out.slot_count, r_out.slot_key, r_out.slot_index};

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (r_state == S_IDLE)) else $error("ready outside idle");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");
    a_clear_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> w_we) else $error("clear sweep without write");
endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for two_choice_hash_packet_counter: random and directed
// count/clear/read words against a built-in slot table model.
// Depends on tchpc_pkg and the RTL of the block.
module testbench;
    import tchpc_pkg::*;

    class slot_table_sb;
        bit [31:0] seed_one, seed_two;
        bit [16:0] tsize;
        bit [31:0] keys[int];
        bit [31:0] counts[int];
        t_result   want_q[$];
        int        errors;

        function new();
            seed_one = 0;
            seed_two = 0;
            tsize    = 17'd65536;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                CFG_SEED_ONE: seed_one = data;
                CFG_SEED_TWO: seed_two = data;
                CFG_TSIZE:    tsize = data[16:0];
                default: ;
            endcase
        endfunction

        function bit [31:0] mix(bit [31:0] key, bit [31:0] seed);
            bit [31:0] k, h;
            k = key * 32'hcc9e2d51;
            k = {k[16:0], k[31:17]};
            k = k * 32'h1b873593;
            h = seed ^ k;
            h = {h[18:0], h[31:19]};
            h = h * 32'd5 + 32'he6546b64;
            h = h ^ 32'd4;
            h = h ^ (h >> 16);
            h = h * 32'h85ebca6b;
            h = h ^ (h >> 13);
            h = h * 32'hc2b2ae35;
            h = h ^ (h >> 16);
            return h;
        endfunction

        function bit [31:0] key_at(int i);
            return keys.exists(i) ? keys[i] : 32'd0;
        endfunction

        function bit [31:0] cnt_at(int i);
            return counts.exists(i) ? counts[i] : 32'd0;
        endfunction

        function bit [31:0] used_slots();
            if (tsize == 0) return 1;
            if (tsize > 17'd65536) return 65536;
            return tsize;
        endfunction

        function void note_word(t_op op, bit [31:0] key, bit [15:0] ridx);
            t_result r;
            int a, b;
            r = '0;
            r.status = ST_DROPPED;
            if (op == OP_CLEAR) begin
                keys.delete();
                counts.delete();
                r.status = ST_CLEARED;
            end else if (op == OP_READ) begin
                r.status = ST_READ;
                r.slot_index = ridx;
                r.slot_key = key_at(ridx);
                r.slot_count = cnt_at(ridx);
            end else if (op == OP_COUNT && key != 0) begin
                a = mix(key, seed_one) % used_slots();
                b = mix(key, seed_two) % used_slots();
                if (key_at(a) == key) begin
                    counts[a] = cnt_at(a) + 1;
                    r = {ST_HIT_ONE, a[15:0], key, counts[a]};
                end else if (key_at(b) == key) begin
                    counts[b] = cnt_at(b) + 1;
                    r = {ST_HIT_TWO, b[15:0], key, counts[b]};
                end else if (key_at(a) == 0) begin
                    keys[a] = key;
                    counts[a] = 1;
                    r = {ST_NEW_ONE, a[15:0], key, 32'd1};
                end else if (key_at(b) == 0) begin
                    keys[b] = key;
                    counts[b] = 1;
                    r = {ST_NEW_TWO, b[15:0], key, 32'd1};
                end
            end
            want_q.push_back(r);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
            errors++;
        endtask

        task check_word(t_result got);
            t_result w;
            if (want_q.size() == 0) begin
                report("unexpected word", 32'(got.slot_index), 32'd0);
                return;
            end
            w = want_q.pop_front();
            if (got.status !== w.status)
                report("status", 32'(got.status), 32'(w.status));
            if (got.slot_index !== w.slot_index)
                report("slot_index", 32'(got.slot_index), 32'(w.slot_index));
            if (got.slot_key !== w.slot_key) report("slot_key", got.slot_key, w.slot_key);
            if (got.slot_count !== w.slot_count) report("slot_count", got.slot_count, w.slot_count);
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    slot_table_sb sb = new();
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    bit [31:0] key_pool[64];

    two_choice_hash_packet_counter dut (.*);

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        m_axis_tready = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                m_axis_tready = 0;
                hold_left--;
            end else begin
                m_axis_tready = ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready)
            sb.check_word({m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[47:16],
                           m_axis_tdata[79:48]});
    end

    always @(posedge i_clk) begin
        if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 300000) begin
            $display("testbench failed");
            $finish;
        end
    end

    // called at a falling edge, returns at a falling edge with valid still high
    task send_word(t_op op, bit [31:0] key, bit [15:0] ridx);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_axis_tvalid = 0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1;
        s_axis_tdata  = {ridx, key};
        s_axis_tuser  = op;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_word(op, key, ridx);
        @(negedge i_clk);
    endtask

    task drain();
        s_axis_tvalid = 0;
        while (sb.want_q.size() != 0) @(negedge i_clk);
    endtask

    task write_reg(logic [1:0] idx, logic [31:0] data);
        drain();
        i_cfg_valid = 1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 0;
    endtask

    task random_words(int n);
        bit [31:0] k;
        int pick;
        repeat (n) begin
            pick = $urandom_range(999);
            k = ($urandom_range(3) == 0) ? $urandom : key_pool[$urandom_range(63)];
            if (pick < 2)
                send_word(OP_CLEAR, $urandom, 16'($urandom));
            else if (pick < 40)
                send_word(OP_NONE, $urandom, 16'($urandom));
            else if (pick < 60)
                send_word(OP_COUNT, 32'd0, 16'($urandom));
            else if (pick < 120)
                send_word(OP_READ, $urandom, 16'($urandom));
            else if (pick < 200)
                send_word(OP_READ, $urandom, 16'($urandom_range(sb.used_slots() - 1)));
            else
                send_word(OP_COUNT, k, 16'($urandom));
        end
    endtask

    initial begin
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_COUNT;
        i_cfg_valid = 0;
        i_cfg_index = CFG_SEED_ONE;
        i_cfg_data = '0;
        foreach (key_pool[i]) key_pool[i] = $urandom | 32'd1;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1;

        send_word(OP_COUNT, 32'hffffffff, 16'h0);
        send_word(OP_COUNT, 32'hffffffff, 16'h0);
        send_word(OP_COUNT, 32'h00000001, 16'hffff);
        send_word(OP_COUNT, 32'h0, 16'h0);
        send_word(OP_NONE, 32'h12345678, 16'h0);
        send_word(OP_READ, 32'h0, 16'h0);
        send_word(OP_READ, 32'h0, 16'hffff);
        send_word(OP_CLEAR, 32'h0, 16'h0);
        send_word(OP_COUNT, 32'hffffffff, 16'h0);
        write_reg(CFG_SEED_ONE, 32'hffffffff);
        write_reg(CFG_SEED_TWO, 32'h0);
        write_reg(CFG_TSIZE, 32'd1);
        write_reg(2'd3, 32'hdeadbeef);
        send_word(OP_COUNT, 32'h0000abcd, 16'h0);
        send_word(OP_COUNT, 32'h0000abcd, 16'h0);
        send_word(OP_COUNT, 32'h80000000, 16'h0);
        send_word(OP_READ, 32'h0, 16'h0);
        write_reg(CFG_TSIZE, 32'd2);
        send_word(OP_COUNT, 32'h00000003, 16'h0);
        send_word(OP_COUNT, 32'h00000005, 16'h0);
        send_word(OP_COUNT, 32'h00000007, 16'h0);
        send_word(OP_COUNT, 32'h00000005, 16'h0);
        send_word(OP_COUNT, 32'h00000007, 16'h0);
        send_word(OP_READ, 32'h0, 16'h1);
        write_reg(CFG_TSIZE, 32'h0001ffff);
        send_word(OP_COUNT, 32'h00000009, 16'h0);

        for (int mode = 0; mode < 3; mode++) begin
            snd_idle_pct = (mode == 0) ? 30 : (mode == 1) ? 83 : 0;
            rcv_idle_pct = (mode == 0) ? 83 : (mode == 1) ? 30 : 0;
            for (int ph = 0; ph < 4; ph++) begin
                write_reg(CFG_SEED_ONE, (ph == 3) ? 32'h0 : $urandom);
                write_reg(CFG_SEED_TWO, (ph == 3) ? 32'hffffffff : $urandom);
                case (ph)
                    0: write_reg(CFG_TSIZE, $urandom_range(16, 2));
                    1: write_reg(CFG_TSIZE, 32'd0);
                    2: write_reg(CFG_TSIZE, $urandom_range(200, 17));
                    default: write_reg(CFG_TSIZE, 32'd65536);
                endcase
                if (mode == 0 && ph == 0) hold_left = 1500;
                random_words(125);
            end
        end

        drain();
        repeat (200) @(negedge i_clk);
        if (sb.errors == 0 && sb.want_q.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule
